FILE: rtl/dptt_pkg.sv
// ---------------------------------------------------------------------------
// dptt_pkg
// Types, constants and codes shared by the transposition table modules.
// ---------------------------------------------------------------------------
package dptt_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int QUEUE_DEPTH       = 2;

	localparam int SCORE_W  = 16;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 8;
	localparam int IN_DATA_W  = 200;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 2;

	localparam logic [CFG_W-1:0] MATE_RESET = 15'd10000;
	localparam logic [CFG_W-1:0] BAN_RESET  = 15'd9900;

	localparam logic [CFG_IDX_W-1:0] REG_MATE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAN  = 8'd1;

	typedef enum logic [1:0] {
		OP_PROBE  = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_EXACT = 2'd1,
		KIND_LOWER = 2'd2,
		KIND_UPPER = 2'd3
	} kind_t;

	typedef struct packed {
		logic [63:0]        key_low;
		logic [63:0]        key_high;
		logic [5:0]         depth;
		logic [15:0]        move;
		logic signed [15:0] score;
		logic [1:0]         kind;
	} entry_t;

	typedef struct packed {
		op_t                op;
		logic               ins_ok;
		logic [63:0]        key_low;
		logic [63:0]        key_high;
		logic [5:0]         depth;
		logic [15:0]        move;
		logic signed [15:0] score;
		logic [1:0]         kind;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] mate;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic signed [SCORE_W-1:0] neg_score(input logic [CFG_W-1:0] v);
		logic [SCORE_W-1:0] r;
		r = 16'd0 - {1'b0, v};
		return $signed(r);
	endfunction

endpackage

FILE: rtl/dptt_ram.sv
// ---------------------------------------------------------------------------
// dptt_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module dptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/dptt_queue.sv
// ---------------------------------------------------------------------------
// dptt_queue
// Short command queue between the front and the back of the table.
// ---------------------------------------------------------------------------
module dptt_queue
	import dptt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic head_valid
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dptt_front.sv
// ---------------------------------------------------------------------------
// dptt_front
// Accepts input items, decodes the opcode, checks the insert score window
// and holds the configuration registers.
// ---------------------------------------------------------------------------
module dptt_front
	import dptt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [IN_USER_W-1:0] s_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  back_stat_t           back_stat,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd,
	output cfg_t                 cfg
);

	logic [CFG_W-1:0]   mate_q;
	logic [CFG_W-1:0]   ban_q;
	logic signed [16:0] score_x;
	logic signed [16:0] ban_x;

	assign cfg_ready = 1'b1;
	assign cfg.mate  = mate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= MATE_RESET;
			ban_q  <= BAN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MATE: mate_q <= cfg_data;
				REG_BAN:  ban_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign s_tready = !q_full && !back_stat.clearing;
	assign q_push   = s_tvalid && s_tready;

	assign score_x = 17'(signed'(s_tdata[165:150]));
	assign ban_x   = $signed({2'b00, ban_q});

	always_comb begin
		q_cmd          = '0;
		q_cmd.op       = op_t'(s_tuser);
		q_cmd.key_low  = s_tdata[63:0];
		q_cmd.key_high = s_tdata[127:64];
		q_cmd.depth    = s_tdata[133:128];
		q_cmd.move     = s_tdata[149:134];
		q_cmd.score    = $signed(s_tdata[165:150]);
		q_cmd.kind     = s_tdata[167:166];
		q_cmd.alpha    = $signed(s_tdata[183:168]);
		q_cmd.beta     = $signed(s_tdata[199:184]);
		q_cmd.ins_ok   = (score_x > -ban_x) && (score_x < ban_x);
	end

endmodule

FILE: rtl/dptt_back.sv
// ---------------------------------------------------------------------------
// dptt_back
// Runs commands against the table memory: read, evaluate and write back,
// and sweeps the memory to clear it after reset and on a clear command.
// ---------------------------------------------------------------------------
module dptt_back
	import dptt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_valid,
	input  cmd_t                  q_cmd,
	output logic                  q_pop,
	output back_stat_t            back_stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int AW = $clog2(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_cnt_q;
	logic signed [15:0]      clr_score_q;
	cmd_t                    cmd_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic [OUT_USER_W-1:0]   out_user_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	entry_t                  ram_wdata;
	entry_t                  ram_rdata;
	logic [$bits(entry_t)-1:0] ram_rdata_raw;

	logic                    out_free;
	logic                    key_hit;
	logic                    deep;
	logic                    bound_hit;
	logic                    take;
	logic signed [15:0]      score_res;
	logic [15:0]             move_res;
	logic [15:0]             any_move_res;
	entry_t                  new_entry;
	entry_t                  clr_entry;

	dptt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_cmd.key_low[AW-1:0]),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	assign back_stat.clearing = (state_q == ST_CLEAR);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_comb begin
		key_hit = (ram_rdata.key_low == cmd_q.key_low) &&
			(ram_rdata.key_high == cmd_q.key_high);
		deep = (ram_rdata.depth >= cmd_q.depth);
		bound_hit = 1'b0;
		if (key_hit && deep) begin
			case (kind_t'(ram_rdata.kind))
				KIND_EXACT: bound_hit = 1'b1;
				KIND_LOWER: bound_hit = (ram_rdata.score >= cmd_q.beta);
				KIND_UPPER: bound_hit = (ram_rdata.score <= cmd_q.alpha);
				default:    bound_hit = 1'b0;
			endcase
		end
		score_res    = bound_hit ? ram_rdata.score : neg_score(cfg.mate);
		move_res     = bound_hit ? ram_rdata.move : 16'd0;
		any_move_res = key_hit ? ram_rdata.move : 16'd0;

		take = cmd_q.ins_ok && ((cmd_q.depth > ram_rdata.depth) ||
			((cmd_q.depth == ram_rdata.depth) && (cmd_q.score > ram_rdata.score)));

		new_entry.key_low  = cmd_q.key_low;
		new_entry.key_high = cmd_q.key_high;
		new_entry.depth    = cmd_q.depth;
		new_entry.move     = cmd_q.move;
		new_entry.score    = cmd_q.score;
		new_entry.kind     = cmd_q.kind;

		clr_entry          = '0;
		clr_entry.score    = clr_score_q;
		clr_entry.kind     = KIND_EMPTY;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmd_q.key_low[AW-1:0];
		ram_wdata = new_entry;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = clr_entry;
			end
			ST_EVAL: begin
				ram_we = out_free && (cmd_q.op == OP_INSERT) && take;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_score_q <= neg_score(MATE_RESET);
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (cmd_q.op == OP_PROBE) begin
							out_data_q <= {any_move_res, move_res, score_res};
							out_user_q <= {key_hit, bound_hit};
						end else begin
							out_data_q <= '0;
							out_user_q <= '0;
						end
						if (cmd_q.op == OP_CLEAR) begin
							state_q     <= ST_CLEAR;
							clr_cnt_q   <= '0;
							clr_score_q <= neg_score(cfg.mate);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/depth_preferred_transposition_table.sv
// ---------------------------------------------------------------------------
// depth_preferred_transposition_table
// Direct-mapped cache of search results with depth-preferred replacement.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  tuser opcode, tdata command fields
// m_axis    out        m_tvalid/m_tready  tuser hit flags, tdata lookup result
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// In the back end a probe or insert is a memory read in ST_IDLE, then
// evaluation and write-back in ST_EVAL on the single write port of the
// table memory. After reset and on every clear command the back end sweeps
// the memory, one entry per cycle, over every entry; no item is accepted then.
// A two-entry queue lets the front accept while the back end works, and
// the output register lets the back end finish while the result waits.
// ---------------------------------------------------------------------------
module depth_preferred_transposition_table
	import dptt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key_low, key_high, search_depth, move_in, score_in, bound_kind,
	// alpha_in, beta_in
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// score_out, move_out, any_move_out
	output logic [OUT_DATA_W-1:0] m_tdata,
	// bound_hit, key_hit
	output logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t       cfg;
	back_stat_t back_stat;
	logic       q_push;
	logic       q_full;
	cmd_t       push_cmd;
	logic       q_pop;
	logic       q_valid;
	cmd_t       head_cmd;

	dptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.back_stat (back_stat),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd),
		.cfg       (cfg)
	);

	dptt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_cmd   (head_cmd),
		.head_valid (q_valid)
	);

	dptt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_cmd     (head_cmd),
		.q_pop     (q_pop),
		.back_stat (back_stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
